### hdl/dtt_pkg.sv
// Shared types, codes and constants for the decimal text to tenths scanner.
package dtt_pkg;

    localparam int MAX_INT_DIGITS = 5;
    localparam int DIGIT_CNT_W    = 3;
    localparam int MAG_W          = 20;
    localparam int VALUE_W        = 16;
    localparam int COUNT_W        = 8;
    localparam int CFG_INDEX_W    = 1;
    localparam int CHECK_W        = MAG_W + 2;

    localparam logic [VALUE_W-1:0] LOWER_BOUND_RST = 16'hFC7C;
    localparam logic [VALUE_W-1:0] UPPER_BOUND_RST = 16'd600;

    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_BOUND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER_BOUND = 1'd1;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EXP_L = 8'h65;
    localparam logic [7:0] CH_EXP_U = 8'h45;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [3:0] ROUND_DIGIT = 4'd5;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_FIRST = 7'b0000010,
        PH_SIGN  = 7'b0000100,
        PH_INT   = 7'b0001000,
        PH_DOT   = 7'b0010000,
        PH_FRAC1 = 7'b0100000,
        PH_SKIP  = 7'b1000000
    } t_phase;

    typedef struct packed {
        logic               bad;
        logic               neg;
        logic [MAG_W-1:0]   mag;
        logic [COUNT_W-1:0] count;
    } t_scan_res;

endpackage

### hdl/dtt_scan.sv
// Byte-serial number scanner: phase, sign, magnitude and byte count state.
module dtt_scan (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_step,
    input  logic [7:0]               i_text_byte,
    input  logic                     i_scan_start,
    input  logic                     i_buffer_end,
    output logic                     o_emit,
    output dtt_pkg::t_scan_res       o_res
);

    dtt_pkg::t_phase                       r_phase, n_phase, eff_phase;
    logic                                  r_neg, n_neg, eff_neg;
    logic [dtt_pkg::MAG_W-1:0]             r_mag, n_mag, eff_mag;
    logic [dtt_pkg::DIGIT_CNT_W-1:0]       r_idig, n_idig, eff_idig;
    logic [3:0]                            r_ffd, n_ffd, eff_ffd;
    logic [dtt_pkg::COUNT_W-1:0]           r_cnt, n_cnt, eff_cnt, cnt_inc;
    logic                                  is_digit, is_expo, is_sign;
    logic [3:0]                            dig;
    logic                                  live, emit_bad, emit_done;
    logic [dtt_pkg::MAG_W-1:0]             mag_x10, nmag_x10, t_mag;

    function automatic logic [dtt_pkg::MAG_W-1:0] times10(input logic [dtt_pkg::MAG_W-1:0] m);
        times10 = (m << 3) + (m << 1);
    endfunction

    always_comb begin
        is_digit = (i_text_byte >= dtt_pkg::CH_ZERO) && (i_text_byte <= dtt_pkg::CH_NINE);
        is_expo  = (i_text_byte == dtt_pkg::CH_EXP_L) || (i_text_byte == dtt_pkg::CH_EXP_U);
        is_sign  = (i_text_byte == dtt_pkg::CH_MINUS) || (i_text_byte == dtt_pkg::CH_PLUS);
        dig      = is_digit ? 4'(i_text_byte - dtt_pkg::CH_ZERO) : 4'd0;

        eff_phase = r_phase;
        eff_neg   = r_neg;
        eff_mag   = r_mag;
        eff_idig  = r_idig;
        eff_ffd   = r_ffd;
        eff_cnt   = r_cnt;
        if (i_scan_start) begin
            eff_phase = dtt_pkg::PH_FIRST;
            eff_neg   = 1'b0;
            eff_mag   = '0;
            eff_idig  = '0;
            eff_ffd   = '0;
            eff_cnt   = '0;
        end

        cnt_inc = (eff_cnt == {dtt_pkg::COUNT_W{1'b1}}) ? eff_cnt : eff_cnt + 1'b1;
        mag_x10 = times10(eff_mag);

        n_phase   = eff_phase;
        n_neg     = eff_neg;
        n_mag     = eff_mag;
        n_idig    = eff_idig;
        n_ffd     = eff_ffd;
        n_cnt     = eff_cnt;
        live      = 1'b1;
        emit_bad  = 1'b0;
        emit_done = 1'b0;

        unique case (eff_phase)
            dtt_pkg::PH_FIRST, dtt_pkg::PH_SIGN: begin
                if (eff_phase == dtt_pkg::PH_FIRST && is_sign) begin
                    n_neg   = (i_text_byte == dtt_pkg::CH_MINUS);
                    n_cnt   = cnt_inc;
                    n_phase = dtt_pkg::PH_SIGN;
                end else if (!is_digit) begin
                    emit_bad = 1'b1;
                end else begin
                    n_mag   = dtt_pkg::MAG_W'(dig);
                    n_idig  = dtt_pkg::DIGIT_CNT_W'(1);
                    n_cnt   = cnt_inc;
                    n_phase = dtt_pkg::PH_INT;
                end
            end
            dtt_pkg::PH_INT: begin
                if (is_digit && (eff_idig < dtt_pkg::DIGIT_CNT_W'(dtt_pkg::MAX_INT_DIGITS))) begin
                    n_mag  = mag_x10 + dtt_pkg::MAG_W'(dig);
                    n_idig = eff_idig + 1'b1;
                    n_cnt  = cnt_inc;
                end else if (is_expo) begin
                    emit_bad = 1'b1;
                end else if (i_text_byte == dtt_pkg::CH_DOT) begin
                    n_cnt   = cnt_inc;
                    n_phase = dtt_pkg::PH_DOT;
                end else begin
                    emit_done = 1'b1;
                end
            end
            dtt_pkg::PH_DOT: begin
                if (!is_digit) begin
                    emit_bad = 1'b1;
                end else begin
                    n_ffd   = dig;
                    n_cnt   = cnt_inc;
                    n_phase = dtt_pkg::PH_FRAC1;
                end
            end
            dtt_pkg::PH_FRAC1: begin
                if (is_digit) begin
                    n_mag   = mag_x10 + dtt_pkg::MAG_W'(eff_ffd)
                              + dtt_pkg::MAG_W'(dig >= dtt_pkg::ROUND_DIGIT);
                    n_cnt   = cnt_inc;
                    n_phase = dtt_pkg::PH_SKIP;
                end else if (is_expo) begin
                    emit_bad = 1'b1;
                end else begin
                    emit_done = 1'b1;
                end
            end
            dtt_pkg::PH_SKIP: begin
                if (is_digit) begin
                    n_cnt = cnt_inc;
                end else if (is_expo) begin
                    emit_bad = 1'b1;
                end else begin
                    emit_done = 1'b1;
                end
            end
            dtt_pkg::PH_IDLE: begin
                live = 1'b0;
            end
            default: begin
                live    = 1'b0;
                n_phase = dtt_pkg::PH_IDLE;
            end
        endcase

        // A flagged last byte closes the scan as though a separator followed it.
        if (live && !emit_bad && !emit_done && i_buffer_end) begin
            if (n_phase == dtt_pkg::PH_SIGN || n_phase == dtt_pkg::PH_DOT) begin
                emit_bad = 1'b1;
            end else begin
                emit_done = 1'b1;
            end
        end

        nmag_x10 = times10(n_mag);
        if (n_phase == dtt_pkg::PH_INT) begin
            t_mag = nmag_x10;
        end else if (n_phase == dtt_pkg::PH_FRAC1) begin
            t_mag = nmag_x10 + dtt_pkg::MAG_W'(n_ffd);
        end else begin
            t_mag = n_mag;
        end

        if (emit_bad || emit_done) begin
            n_phase = dtt_pkg::PH_IDLE;
        end

        o_emit      = emit_bad || emit_done;
        o_res.bad   = emit_bad;
        o_res.neg   = n_neg;
        o_res.mag   = t_mag;
        o_res.count = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dtt_pkg::PH_IDLE;
            r_neg   <= 1'b0;
            r_mag   <= '0;
            r_idig  <= '0;
            r_ffd   <= '0;
            r_cnt   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_mag   <= n_mag;
            r_idig  <= n_idig;
            r_ffd   <= n_ffd;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### hdl/decimal_text_to_tenths_core.sv
// Top level of the decimal text to tenths scanner with bounds check and result register.
//
// The block takes one ASCII byte per beat and can accept a byte in every clock cycle
// unless a held result stalls it. A byte passes an input register, then the scanner state
// machine, which updates its state and may produce a result for the result register, then
// a bounds check that fills the output register. The recurrence of the scanner state (a
// multiply by ten and add on the magnitude) sets the rate of one byte per cycle while not
// stalled. A separator byte that ends a number is not counted in bytes_used, and a scan
// running when a new scan_start byte arrives is dropped without a result. The user must
// write the bounds registers only while no scan is in flight; it is not enforced.
module decimal_text_to_tenths_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [7:0]                          i_text_byte,
    input  logic                                i_scan_start,
    input  logic                                i_buffer_end,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_scan_status,
    output logic signed [dtt_pkg::VALUE_W-1:0]  o_tenths_value,
    output logic [dtt_pkg::COUNT_W-1:0]         o_bytes_used,
    input  logic                                i_cfg_we,
    input  logic [dtt_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [dtt_pkg::VALUE_W-1:0]         i_cfg_data
);

    logic [dtt_pkg::VALUE_W-1:0]  r_lower_bound, r_upper_bound;
    logic                         r_a_valid;
    logic [7:0]                   r_a_byte;
    logic                         r_a_start, r_a_last;
    logic                         r_b_valid;
    dtt_pkg::t_scan_res           r_b_res;
    logic                         r_out_valid;
    logic [1:0]                   r_status;
    logic [dtt_pkg::VALUE_W-1:0]  r_value;
    logic [dtt_pkg::COUNT_W-1:0]  r_bytes;
    logic                         ready_c, ready_b, step, in_accept, scan_emit;
    dtt_pkg::t_scan_res           scan_res;
    logic signed [dtt_pkg::CHECK_W-1:0] mag_s, val_s, lo_s, hi_s;
    dtt_pkg::t_status             n_status;
    logic [dtt_pkg::VALUE_W-1:0]  n_value;
    logic [dtt_pkg::COUNT_W-1:0]  n_bytes;

    assign ready_c    = !r_out_valid || !i_out_stall;
    assign ready_b    = !r_b_valid || ready_c;
    assign step       = r_a_valid && ready_b;
    assign o_in_stall = r_a_valid && !ready_b;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_bound <= dtt_pkg::LOWER_BOUND_RST;
            r_upper_bound <= dtt_pkg::UPPER_BOUND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dtt_pkg::REG_LOWER_BOUND: r_lower_bound <= i_cfg_data;
                dtt_pkg::REG_UPPER_BOUND: r_upper_bound <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_accept) begin
            r_a_valid <= 1'b1;
        end else if (step) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_byte  <= i_text_byte;
            r_a_start <= i_scan_start;
            r_a_last  <= i_buffer_end;
        end
    end

    dtt_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_text_byte  (r_a_byte),
        .i_scan_start (r_a_start),
        .i_buffer_end (r_a_last),
        .o_emit       (scan_emit),
        .o_res        (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= step && scan_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_b && step && scan_emit) begin
            r_b_res <= scan_res;
        end
    end

    always_comb begin
        mag_s = $signed({2'b00, r_b_res.mag});
        val_s = r_b_res.neg ? -mag_s : mag_s;
        lo_s  = dtt_pkg::CHECK_W'($signed(r_lower_bound));
        hi_s  = dtt_pkg::CHECK_W'($signed(r_upper_bound));
        if (r_b_res.bad) begin
            n_status = dtt_pkg::ST_BAD;
            n_value  = '0;
            n_bytes  = '0;
        end else if (val_s < lo_s || val_s > hi_s) begin
            n_status = dtt_pkg::ST_RANGE;
            n_value  = '0;
            n_bytes  = r_b_res.count;
        end else begin
            n_status = dtt_pkg::ST_OK;
            n_value  = val_s[dtt_pkg::VALUE_W-1:0];
            n_bytes  = r_b_res.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ready_c) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_c && r_b_valid) begin
            r_status <= n_status;
            r_value  <= n_value;
            r_bytes  <= n_bytes;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_scan_status  = r_status;
    assign o_tenths_value = $signed(r_value);
    assign o_bytes_used   = r_bytes;

endmodule

### hdl/dtt_check.sv
// Port-level checker for the scanner top level and its bind statement.
module dtt_check (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [1:0]                          o_scan_status,
    input  logic signed [dtt_pkg::VALUE_W-1:0]  o_tenths_value,
    input  logic [dtt_pkg::COUNT_W-1:0]         o_bytes_used
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_scan_status)
            && $stable(o_tenths_value) && $stable(o_bytes_used))
        else $error("Stalled result beat changed.");

    a_no_value_unless_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_scan_status != dtt_pkg::ST_OK) |-> o_tenths_value == '0)
        else $error("Rejected result carries a value.");

    a_bad_has_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_scan_status == dtt_pkg::ST_BAD) |-> o_bytes_used == '0)
        else $error("Malformed result reports consumed bytes.");

    a_good_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_scan_status == dtt_pkg::ST_OK || o_scan_status == dtt_pkg::ST_RANGE)
            |-> o_bytes_used != '0)
        else $error("Finished number reports no consumed bytes.");

endmodule

bind decimal_text_to_tenths_core dtt_check u_dtt_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_scan_status  (o_scan_status),
    .o_tenths_value (o_tenths_value),
    .o_bytes_used   (o_bytes_used)
);

### tb/sv/decimal_text_to_tenths_checker.sv
// Checker that tracks the scanner's channels, predicts each result and compares it.
module decimal_text_to_tenths_checker
    import dtt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [7:0]             i_text_byte,
    input  logic                   i_scan_start,
    input  logic                   i_buffer_end,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [1:0]             i_scan_status,
    input  logic [VALUE_W-1:0]     i_tenths_value,
    input  logic [COUNT_W-1:0]     i_bytes_used,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [VALUE_W-1:0]     i_cfg_data,
    output int                     o_failures,
    output int                     o_pending
);

    typedef struct {
        t_status            status;
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] used;
    } t_tenths_result;

    t_tenths_result tenths_q[$];
    t_tenths_result want;

    t_phase                 phase;
    logic                   neg;
    logic [MAG_W-1:0]       mag;
    logic [DIGIT_CNT_W-1:0] int_digits;
    logic [3:0]             frac_digit;
    logic [COUNT_W-1:0]     used_bytes;
    int                     lower;
    int                     upper;
    int                     failures = 0;
    int                     result_no = 0;

    task automatic report_mismatch(input string msg);
        failures++;
        if (failures <= 40) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
    endtask

    task automatic count_byte();
        if (used_bytes != '1) begin
            used_bytes = used_bytes + 1'b1;
        end
    endtask

    function automatic t_tenths_result close_number(input logic malformed);
        t_tenths_result r;
        int t;
        int v;
        r.status = ST_BAD;
        r.value = '0;
        r.used = '0;
        if (!malformed) begin
            case (phase)
                PH_INT:   t = int'(mag) * 10;
                PH_FRAC1: t = int'(mag) * 10 + int'(frac_digit);
                default:  t = int'(mag);
            endcase
            v = neg ? -t : t;
            r.used = used_bytes;
            if (v < lower || v > upper) begin
                r.status = ST_RANGE;
            end else begin
                r.status = ST_OK;
                r.value = VALUE_W'(v);
            end
        end
        return r;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic start, input logic last);
        logic       is_digit;
        logic       is_exp;
        logic       done;
        logic       malformed;
        logic [3:0] d;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        is_exp = (b == CH_EXP_L) || (b == CH_EXP_U);
        d = is_digit ? 4'(b - CH_ZERO) : 4'd0;
        done = 1'b0;
        malformed = 1'b0;
        if (start) begin
            neg = 1'b0;
            mag = '0;
            int_digits = '0;
            frac_digit = '0;
            used_bytes = '0;
            phase = PH_FIRST;
        end
        case (phase)
            PH_FIRST, PH_SIGN: begin
                if (phase == PH_FIRST && (b == CH_MINUS || b == CH_PLUS)) begin
                    neg = (b == CH_MINUS);
                    count_byte();
                    phase = PH_SIGN;
                end else if (!is_digit) begin
                    done = 1'b1;
                    malformed = 1'b1;
                end else begin
                    mag = MAG_W'(d);
                    int_digits = DIGIT_CNT_W'(1);
                    count_byte();
                    phase = PH_INT;
                end
            end
            PH_INT: begin
                if (is_digit && int'(int_digits) < MAX_INT_DIGITS) begin
                    mag = MAG_W'(int'(mag) * 10 + int'(d));
                    int_digits = int_digits + 1'b1;
                    count_byte();
                end else if (is_exp) begin
                    done = 1'b1;
                    malformed = 1'b1;
                end else if (b == CH_DOT) begin
                    count_byte();
                    phase = PH_DOT;
                end else begin
                    done = 1'b1;
                end
            end
            PH_DOT: begin
                if (!is_digit) begin
                    done = 1'b1;
                    malformed = 1'b1;
                end else begin
                    frac_digit = d;
                    count_byte();
                    phase = PH_FRAC1;
                end
            end
            PH_FRAC1: begin
                if (is_digit) begin
                    mag = MAG_W'(int'(mag) * 10 + int'(frac_digit)
                                 + ((d >= ROUND_DIGIT) ? 1 : 0));
                    count_byte();
                    phase = PH_SKIP;
                end else if (is_exp) begin
                    done = 1'b1;
                    malformed = 1'b1;
                end else begin
                    done = 1'b1;
                end
            end
            PH_SKIP: begin
                if (is_digit) begin
                    count_byte();
                end else if (is_exp) begin
                    done = 1'b1;
                    malformed = 1'b1;
                end else begin
                    done = 1'b1;
                end
            end
            default: phase = PH_IDLE;
        endcase
        // A running scan closes on the last byte of the buffer.
        if (!done && last && phase != PH_IDLE) begin
            done = 1'b1;
            malformed = (phase == PH_SIGN) || (phase == PH_DOT);
        end
        if (done) begin
            tenths_q.push_back(close_number(malformed));
            phase = PH_IDLE;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase = PH_IDLE;
            neg = 1'b0;
            mag = '0;
            int_digits = '0;
            frac_digit = '0;
            used_bytes = '0;
            lower = int'($signed(LOWER_BOUND_RST));
            upper = int'($signed(UPPER_BOUND_RST));
            tenths_q.delete();
        end else begin
            if (i_cfg_we === 1'b1) begin
                if (i_cfg_index == REG_LOWER_BOUND) begin
                    lower = int'($signed(i_cfg_data));
                end else if (i_cfg_index == REG_UPPER_BOUND) begin
                    upper = int'($signed(i_cfg_data));
                end
            end
            if (i_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                result_no++;
                if (tenths_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d not expected: status %0d value %0d used %0d",
                                              result_no, i_scan_status,
                                              $signed(i_tenths_value), i_bytes_used));
                end else begin
                    want = tenths_q.pop_front();
                    if (i_scan_status !== want.status) begin
                        report_mismatch($sformatf("result %0d: scan_status got %0d, expected %0d",
                                                  result_no, i_scan_status, want.status));
                    end
                    if (i_tenths_value !== want.value) begin
                        report_mismatch($sformatf("result %0d: tenths_value got %0d, expected %0d",
                                                  result_no, $signed(i_tenths_value),
                                                  $signed(want.value)));
                    end
                    if (i_bytes_used !== want.used) begin
                        report_mismatch($sformatf("result %0d: bytes_used got %0d, expected %0d",
                                                  result_no, i_bytes_used, want.used));
                    end
                end
            end
            if (i_in_valid === 1'b1 && i_in_stall === 1'b0) begin
                scan_byte(i_text_byte, i_scan_start, i_buffer_end);
            end
        end
        o_pending <= tenths_q.size();
        o_failures <= failures;
    end

endmodule

### tb/sv/decimal_text_to_tenths_core_tb.sv
// Testbench top that drives text beats and bound writes into the scanner and gives the verdict.
module decimal_text_to_tenths_core_tb;
    import dtt_pkg::*;

    localparam int HOLD_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_BYTES  = 480;
    localparam int PHASES        = 6;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_stall;
    logic [7:0]                text_byte = '0;
    logic                      scan_start = 1'b0;
    logic                      buffer_end = 1'b0;
    logic                      out_valid;
    logic                      out_stall = 1'b0;
    logic [1:0]                scan_status;
    logic signed [VALUE_W-1:0] tenths_value;
    logic [COUNT_W-1:0]        bytes_used;
    logic                      cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]    cfg_index = REG_LOWER_BOUND;
    logic [VALUE_W-1:0]        cfg_data = '0;

    int         failures;
    int         pending;
    int         burst_left = 0;
    int         sent_bytes = 0;
    int         cycle_count = 0;
    bit         random_on = 1'b0;
    logic [7:0] seq_q[$];

    always #5 clk = ~clk;

    decimal_text_to_tenths_core DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_text_byte    (text_byte),
        .i_scan_start   (scan_start),
        .i_buffer_end   (buffer_end),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_scan_status  (scan_status),
        .o_tenths_value (tenths_value),
        .o_bytes_used   (bytes_used),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    decimal_text_to_tenths_checker checker_i (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_text_byte    (text_byte),
        .i_scan_start   (scan_start),
        .i_buffer_end   (buffer_end),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_scan_status  (scan_status),
        .i_tenths_value (tenths_value),
        .i_bytes_used   (bytes_used),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_failures     (failures),
        .o_pending      (pending)
    );

    task automatic put_byte(input logic [7:0] b, input logic s, input logic e);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        text_byte <= b;
        scan_start <= s;
        buffer_end <= e;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        burst_left--;
        sent_bytes++;
    endtask

    task automatic send_seq(input logic end_last);
        foreach (seq_q[k]) begin
            put_byte(seq_q[k], k == 0, end_last && (k == seq_q.size() - 1));
        end
        seq_q.delete();
    endtask

    task automatic send_text(input string s, input logic end_last);
        seq_q.delete();
        for (int k = 0; k < s.len(); k++) begin
            seq_q.push_back(s[k]);
        end
        send_seq(end_last);
    endtask

    function automatic logic [7:0] random_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic send_random_number(input int frac_len);
        int         shape;
        int         pick;
        int         n_int;
        int         n_frac;
        int         sign_len;
        logic       end_last;
        shape = (frac_len >= 0) ? 50 : $urandom_range(0, 99);
        if (shape < 10) begin
            repeat ($urandom_range(1, 4)) begin
                put_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0,
                         $urandom_range(0, 3) == 0);
            end
            return;
        end
        seq_q.delete();
        sign_len = 0;
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            seq_q.push_back(CH_MINUS);
            sign_len = 1;
        end else if (pick == 1) begin
            seq_q.push_back(CH_PLUS);
            sign_len = 1;
        end
        pick = $urandom_range(0, 9);
        n_int = (pick < 6) ? $urandom_range(1, 3) :
                (pick < 9) ? $urandom_range(4, 5) : $urandom_range(6, 7);
        repeat (n_int) seq_q.push_back(random_digit());
        n_frac = frac_len;
        if (frac_len < 0) begin
            pick = $urandom_range(0, 3);
            n_frac = (pick == 0) ? -1 : (pick == 1) ? 1 :
                     (pick == 2) ? 2 : $urandom_range(3, 5);
        end
        if (shape < 16) begin
            n_frac = 0;
        end
        if (n_frac >= 0) begin
            seq_q.push_back(CH_DOT);
            repeat (n_frac) seq_q.push_back(random_digit());
        end
        if (shape >= 16 && shape < 22) begin
            seq_q.push_back(($urandom_range(0, 1) != 0) ? CH_EXP_L : CH_EXP_U);
        end
        if (shape >= 22 && shape < 28) begin
            seq_q.insert(sign_len, 8'($urandom_range(0, 255)));
        end
        end_last = ($urandom_range(0, 4) == 0);
        send_seq(end_last);
        if (!end_last) begin
            case ($urandom_range(0, 5))
                0: put_byte(" ", 1'b0, 1'b0);
                1: put_byte(",", 1'b0, 1'b0);
                2: put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                3: put_byte(($urandom_range(0, 1) != 0) ? CH_EXP_L : CH_EXP_U, 1'b0, 1'b0);
                4: ;
                default: put_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            endcase
        end
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic set_bounds(input int lo, input int hi);
        cfg_we <= 1'b1;
        cfg_index <= REG_LOWER_BOUND;
        cfg_data <= VALUE_W'(lo);
        @(posedge clk);
        cfg_index <= REG_UPPER_BOUND;
        cfg_data <= VALUE_W'(hi);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        int lo;
        int hi;
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed beats under the reset bounds.
        put_byte(8'hFF, 1'b0, 1'b0);
        send_text("-5.25", 1'b0);
        put_byte(8'h00, 1'b0, 1'b0);
        send_text("12", 1'b0);
        send_text("+a", 1'b0);
        send_text("7.", 1'b1);
        send_text("3e", 1'b0);
        send_text("999999", 1'b0);
        send_text("9", 1'b1);
        wait_for_results();

        random_on = 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin lo = -32768; hi = 32767; end
                1: begin lo = 32767;  hi = -32768; end
                2: begin lo = -2000;  hi = 0; end
                3: begin lo = 0;      hi = 1500; end
                4: begin
                    lo = $urandom_range(0, 4000) - 3000;
                    hi = lo + $urandom_range(0, 6000);
                end
                default: begin lo = -50; hi = 50; end
            endcase
            set_bounds(lo, hi);
            if (p == 0) begin
                send_text("-3276.8", 1'b1);
                send_text("3276.7", 1'b1);
                send_random_number(255);
            end
            target = sent_bytes + RANDOM_BYTES / PHASES;
            while (sent_bytes < target) send_random_number(-1);
            // Close any open scan so the bounds can be rewritten safely.
            put_byte(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            wait_for_results();
        end

        if (failures == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : receiver
        int  mode;
        int  len;
        bit  held;
        held = 1'b0;
        @(posedge clk);
        forever begin
            if (random_on && !held) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                held = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                len = $urandom_range(4, 40);
                repeat (len) begin
                    case (mode)
                        0: out_stall <= 1'b0;
                        1: out_stall <= ($urandom_range(0, 3) == 0);
                        2: out_stall <= ($urandom_range(0, 3) != 0);
                        default: out_stall <= ~out_stall;
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TEST FAILED");
        $finish;
    end

endmodule
